// ===== hw/rtl/lact_pkg.sv =====
// ----------------------------------------------------------------------------
// lact_pkg
// Shared types and constants for the LRU associative cache tracker.
// ----------------------------------------------------------------------------
package lact_pkg;

    localparam int KEY_W           = 32;
    localparam int STAT_W          = 32;
    localparam int CAP_W           = 5;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Commands carried in s_tuser
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             cmp_en;   // capture compare result
        logic             upd;      // apply a lookup update this cycle
        logic             hit;      // lookup found its key
        logic             evict;    // lookup misses with no room
        logic [KEY_W-1:0] key;      // key being looked up
    } cell_ctrl_t;

    // Per-cell position flags decoded from the fill level
    typedef struct packed {
        logic valid;      // cell index below fill level
        logic is_top;     // most recent occupied cell
        logic is_append;  // first free cell
    } cell_pos_t;

endpackage

// ===== hw/rtl/lact_cell.sv =====
// ----------------------------------------------------------------------------
// lact_cell
// One entry of the LRU chain: holds a key, compares it, shifts toward LRU.
// ----------------------------------------------------------------------------
module lact_cell
    import lact_pkg::*;
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  cell_pos_t        pos,
    input  logic [KEY_W-1:0] nbr_key,    // key of the next more recent cell
    input  logic             shift_in,   // a hit lies at a lower index
    output logic             shift_out,
    output logic [KEY_W-1:0] key
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             match_reg;
    logic             load_next;
    logic             load_new;

    assign shift_out = shift_in | (match_reg & pos.valid);

    assign load_next = ctrl.upd & pos.valid & ~pos.is_top
                     & (ctrl.evict | (ctrl.hit & shift_out));
    assign load_new  = ctrl.upd
                     & ((pos.is_top & (ctrl.hit | ctrl.evict))
                     | (pos.is_append & ~ctrl.hit & ~ctrl.evict));

    always_comb
    begin
        key_next = key_reg;
        if (load_new)
        begin
            key_next = ctrl.key;
        end
        else if (load_next)
        begin
            key_next = nbr_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (ctrl.cmp_en)
        begin
            match_reg <= (key_reg == ctrl.key);
        end
    end

    assign key = key_reg;

endmodule

// ===== hw/rtl/lru_assoc_cache_tracker.sv =====
// ----------------------------------------------------------------------------
// lru_assoc_cache_tracker
// Fully associative key store with LRU replacement and hit statistics.
// ----------------------------------------------------------------------------
// Each item passes through three steps: the accept step, a compare step in
// which every cell registers its key match, and an update step in which the
// cell chain shifts and the result item is loaded into the output register.
// The compare register inside the cells adds the compare step; a clear
// command skips the compare, so it has two steps. The update waits while
// an earlier result is still held on the master side. Keys of cells at or
// above the occupancy are never read, so reset needs no clearing pass.
module lru_assoc_cache_tracker
    import lact_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // slave side: tdata = key[31:0]; tuser = cmd
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [KEY_W-1:0]  s_tdata,
    input  logic              s_tuser,
    // master side: tdata = hit[0], evicted_valid[1], evicted_key[33:2],
    //   hit_count[65:34], access_count[97:66], occupancy[102:98], zero[103]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [103:0]      m_tdata,
    // capacity register write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CAP_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    state_t             state_reg, state_next;
    logic               cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [STAT_W-1:0]  hits_reg, hits_next;
    logic [STAT_W-1:0]  acc_reg, acc_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg, out_hit_next;
    logic               out_ev_reg, out_ev_next;
    logic [KEY_W-1:0]   out_evkey_reg, out_evkey_next;
    logic [STAT_W-1:0]  out_hits_reg, out_hits_next;
    logic [STAT_W-1:0]  out_acc_reg, out_acc_next;
    logic [CAP_W-1:0]   out_occ_reg, out_occ_next;

    logic               s_fire;
    logic               go;         // update cycle that may load the output
    logic               hit;
    logic               room;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   limit;
    cell_ctrl_t         ctrl;

    logic [MAX_ENTRIES-1:0]  shift_chain;
    logic [KEY_W-1:0]        cell_key [MAX_ENTRIES];
    cell_pos_t               cell_pos [MAX_ENTRIES];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;

    // Capacity in use: zero acts as one, clamped to the store depth.
    assign cap_ext = CMP_W'(cap_reg);
    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(MAX_ENTRIES))
        begin
            limit = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            limit = cap_ext;
        end
    end
    assign room = (CMP_W'(fill_reg) < limit);

    // End of the prefix chain: some occupied cell matched.
    assign hit = shift_chain[MAX_ENTRIES-1];

    assign go = (state_reg == ST_UPD) & (~out_valid_reg | m_tready);

    assign ctrl.cmp_en = (state_reg == ST_CMP);
    assign ctrl.upd    = go & (cmd_reg == CMD_LOOKUP);
    assign ctrl.hit    = hit;
    assign ctrl.evict  = ~hit & ~room;
    assign ctrl.key    = key_reg;

    // Cell row: index 0 is least recent.
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [KEY_W-1:0] nbr;
        logic             sin;

        assign cell_pos[i].valid     = (CNT_W'(i) < fill_reg);
        assign cell_pos[i].is_top    = (fill_reg == CNT_W'(i + 1));
        assign cell_pos[i].is_append = (fill_reg == CNT_W'(i));

        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_key[i+1];
        end

        if (i == 0)
        begin : g_first
            assign sin = 1'b0;
        end
        else
        begin : g_rest
            assign sin = shift_chain[i-1];
        end

        lact_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .pos       (cell_pos[i]),
            .nbr_key   (nbr),
            .shift_in  (sin),
            .shift_out (shift_chain[i]),
            .key       (cell_key[i])
        );
    end

    // Sequencer and statistics
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        fill_next      = fill_reg;
        hits_next      = hits_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        out_hit_next   = out_hit_reg;
        out_ev_next    = out_ev_reg;
        out_evkey_next = out_evkey_reg;
        out_hits_next  = out_hits_reg;
        out_acc_next   = out_acc_reg;
        out_occ_next   = out_occ_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    cmd_next   = s_tuser;
                    key_next   = s_tdata;
                    state_next = (s_tuser == CMD_CLEAR) ? ST_UPD : ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        fill_next      = '0;
                        hits_next      = '0;
                        acc_next       = '0;
                        out_hit_next   = 1'b0;
                        out_ev_next    = 1'b0;
                        out_evkey_next = '0;
                    end
                    else
                    begin
                        acc_next = (&acc_reg) ? acc_reg : acc_reg + 1'b1;
                        if (hit)
                        begin
                            hits_next = (&hits_reg) ? hits_reg : hits_reg + 1'b1;
                        end
                        else if (room)
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        out_hit_next   = hit;
                        out_ev_next    = ctrl.evict;
                        out_evkey_next = ctrl.evict ? cell_key[0] : '0;
                    end
                    out_hits_next = hits_next;
                    out_acc_next  = acc_next;
                    out_occ_next  = CAP_W'(fill_next);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            fill_reg      <= '0;
            hits_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            hits_reg      <= hits_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid & cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        out_hit_reg   <= out_hit_next;
        out_ev_reg    <= out_ev_next;
        out_evkey_reg <= out_evkey_next;
        out_hits_reg  <= out_hits_next;
        out_acc_reg   <= out_acc_next;
        out_occ_reg   <= out_occ_next;
    end

    assign m_tdata = {1'b0, out_occ_reg, out_acc_reg, out_hits_reg,
                      out_evkey_reg, out_ev_reg, out_hit_reg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(MAX_ENTRIES) >= fill_reg)
        else $error("fill level above store depth");

    a_hit_xor_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_ev_reg))
        else $error("result both hit and eviction");

    a_stats_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_hits_reg <= out_acc_reg))
        else $error("hit count above access count");

    a_update_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.upd && (hit || ctrl.evict)) |=> $stable(fill_reg))
        else $error("fill level moved on hit or eviction");

endmodule

// ===== test/lru_tracker_check_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_tracker_check_pkg
// Result layout and scoreboard for the LRU associative cache tracker bench.
// ----------------------------------------------------------------------------
package lru_tracker_check_pkg;

    import lact_pkg::*;

    localparam int REPORT_LIMIT = 200;

    // Master-side tdata, lowest field last
    typedef struct packed {
        logic              pad;
        logic [CAP_W-1:0]  occupancy;
        logic [STAT_W-1:0] access_count;
        logic [STAT_W-1:0] hit_count;
        logic [KEY_W-1:0]  evicted_key;
        logic              evicted_valid;
        logic              hit;
    } tracker_result_t;

    class lru_tracker_sb;

        // LRU order: index 0 least recent, held-1 most recent
        logic [KEY_W-1:0]  lru_keys [MAX_ENTRIES_DEF];
        int unsigned       held;
        logic [STAT_W-1:0] hit_tally;
        logic [STAT_W-1:0] lookup_tally;
        logic [CAP_W-1:0]  cap_setting;
        tracker_result_t   due_results [$];
        int unsigned       errors;

        function new();
            held         = 0;
            hit_tally    = '0;
            lookup_tally = '0;
            cap_setting  = CAP_RESET;
            errors       = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            cap_setting = value;
        endfunction

        function logic [STAT_W-1:0] bump(logic [STAT_W-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        // Predict the result of one accepted item and queue it
        function void accept_item(logic cmd, logic [KEY_W-1:0] key);
            tracker_result_t want;
            int              found;
            int unsigned     lim;
            int unsigned     i;
            want  = '0;
            found = -1;
            if (cmd == CMD_CLEAR)
            begin
                held         = 0;
                hit_tally    = '0;
                lookup_tally = '0;
            end
            else
            begin
                lookup_tally = bump(lookup_tally);
                for (i = 0; i < held; i++)
                begin
                    if (found < 0 && lru_keys[i] == key)
                        found = i;
                end
                // zero means one, anything past the array means all of it
                lim = (cap_setting == 0) ? 1 :
                      (cap_setting > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : cap_setting;
                if (found >= 0)
                begin
                    for (i = found + 1; i < held; i++)
                        lru_keys[i-1] = lru_keys[i];
                    lru_keys[held-1] = key;
                    want.hit  = 1'b1;
                    hit_tally = bump(hit_tally);
                end
                else if (held < lim)
                begin
                    lru_keys[held] = key;
                    held++;
                end
                else
                begin
                    // also covers capacity lowered below the fill: no trim
                    want.evicted_valid = 1'b1;
                    want.evicted_key   = lru_keys[0];
                    for (i = 1; i < held; i++)
                        lru_keys[i-1] = lru_keys[i];
                    lru_keys[held-1] = key;
                end
            end
            want.hit_count    = hit_tally;
            want.access_count = lookup_tally;
            want.occupancy    = held[CAP_W-1:0];
            due_results = {due_results, want};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $error("%s: expected %0h, actual %0h", name, want, got);
            end
        endfunction

        function void check_result(logic [103:0] data);
            tracker_result_t got;
            tracker_result_t want;
            got = tracker_result_t'(data);
            if (due_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $error("result with none expected: %0h", data);
                return;
            end
            want = due_results.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("evicted_valid", want.evicted_valid, got.evicted_valid);
            compare_field("evicted_key", want.evicted_key, got.evicted_key);
            compare_field("hit_count", want.hit_count, got.hit_count);
            compare_field("access_count", want.access_count, got.access_count);
            compare_field("occupancy", want.occupancy, got.occupancy);
            compare_field("pad", want.pad, got.pad);
        endfunction

    endclass

endpackage

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Bench for the LRU associative cache tracker: a short directed run over
// key extremes, clears and capacity corner values, then random phases of
// lookups over small key sets under varying capacity, with random gaps on
// the input side and random stalls on the output side. Every result is
// checked field by field against a scoreboard that tracks the LRU order.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lact_pkg::*;
    import lru_tracker_check_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 105;
    localparam int POOL_MAX       = 24;
    localparam int DRAIN_CYCLES   = 8;     // idle slack after the last result returns

    logic              clk = 1'b0;
    logic              rst_n;

    // slave side: tdata = key[31:0]; tuser = cmd
    logic              s_tvalid;
    logic              s_tready;
    logic [KEY_W-1:0]  s_tdata;
    logic              s_tuser;
    // master side: tdata = hit[0], evicted_valid[1], evicted_key[33:2],
    //   hit_count[65:34], access_count[97:66], occupancy[102:98], zero[103]
    logic              m_tvalid;
    logic              m_tready;
    logic [103:0]      m_tdata;
    // capacity write channel
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CAP_W-1:0]  cfg_data;

    lru_tracker_sb     sb;
    int unsigned       tx_burst = 0;   // items left to send back to back
    int unsigned       idle_cycles = 0;

    always #2 clk = ~clk;

    lru_assoc_cache_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Send one item: optional gap, then hold tvalid until tready.
    // tvalid stays up after acceptance so back-to-back items never
    // see a low/high pair in one step.
    task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key);
        int unsigned gap;
        gap = 0;
        if (tx_burst > 0)
            tx_burst--;
        else
        begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0)
                tx_burst = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= key;
        do @(posedge clk); while (!s_tready);
        sb.accept_item(cmd, key);
    endtask

    // Capacity writes only with the pipe empty: every result back, then
    // a few cycles of slack for the block's internal stages.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_capacity(value);
    endtask

    // Result sink: random stall per item, with occasional stall-free runs
    initial
    begin : result_sink
        int unsigned stall;
        int unsigned rx_burst;
        rx_burst = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = 0;
            if (rx_burst > 0)
                rx_burst--;
            else
            begin
                stall = $urandom_range(0, 6);
                if ($urandom_range(0, 15) == 0)
                    rx_burst = $urandom_range(5, 40);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    // Watchdog: any handshake resets the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [KEY_W-1:0] key_pool [POOL_MAX];
        int unsigned      pool_size;
        int unsigned      phase;
        int unsigned      n;
        int unsigned      pick;
        logic [CAP_W-1:0] cap;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_LOOKUP;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: key extremes, hits at both ends and in the middle
        send_item(CMD_LOOKUP, 32'h0000_0000);
        send_item(CMD_LOOKUP, 32'h7FFF_FFFF);
        send_item(CMD_LOOKUP, 32'h8000_0000);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF);
        send_item(CMD_LOOKUP, 32'h0000_0000);    // hit on least recent
        send_item(CMD_LOOKUP, 32'h8000_0000);    // hit in the middle
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF);    // hit on the second least recent

        // capacity dropped under the fill: misses evict, fill stays at 4
        write_capacity(5'd2);
        send_item(CMD_LOOKUP, 32'h1234_5678);
        send_item(CMD_LOOKUP, 32'h0000_0000);
        send_item(CMD_LOOKUP, 32'hCAFE_0001);

        // clear ignores its key
        send_item(CMD_CLEAR, 32'hA5A5_A5A5);

        // zero capacity behaves as one
        write_capacity(5'd0);
        send_item(CMD_LOOKUP, 32'h0000_0001);
        send_item(CMD_LOOKUP, 32'h0000_0002);
        send_item(CMD_LOOKUP, 32'h0000_0002);
        send_item(CMD_LOOKUP, 32'h8000_0000);

        // above the array size clamps to the full array
        write_capacity(5'd31);
        send_item(CMD_CLEAR, 32'h0000_0000);
        for (n = 0; n < 17; n++)
            send_item(CMD_LOOKUP, {$urandom_range(0, 1) ? 28'h8000_000 : 28'h0, n[3:0]});

        // --- random phases: small key pools around the capacity
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       cap = 5'd1;
                1:       cap = 5'd16;
                2:       cap = 5'd31;
                3:       cap = 5'd0;
                4:       cap = 5'd17;
                default: cap = CAP_W'($urandom_range(0, 31));
            endcase
            write_capacity(cap);
            pool_size = $urandom_range(2, POOL_MAX);
            for (n = 0; n < POOL_MAX; n++)
                key_pool[n] = $urandom;
            // leave the old contents in about half the time
            if ($urandom_range(0, 1) == 0)
                send_item(CMD_CLEAR, $urandom);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    send_item(CMD_CLEAR, $urandom);
                else if (pick < 15)
                    send_item(CMD_LOOKUP, $urandom);
                else
                    send_item(CMD_LOOKUP, key_pool[$urandom_range(0, pool_size - 1)]);
            end
        end

        s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lact_pkg.sv
hw/rtl/lact_cell.sv
hw/rtl/lru_assoc_cache_tracker.sv
test/lru_tracker_check_pkg.sv
test/tb_top.sv
